// ===== src/wmdg_pkg.sv =====
// shared constants and types of the window median depth gate
package wmdg_pkg;

    localparam int WINDOW_RADIUS = 4;
    localparam int WIN_SIDE      = 2 * WINDOW_RADIUS;
    localparam int WIN_COUNT     = WIN_SIDE * WIN_SIDE;
    localparam int MED_RANK      = WIN_COUNT / 2;
    localparam int CNT_W         = $clog2(WIN_COUNT + 1);

    localparam int DEPTH_W  = 16;
    localparam int EDGE_W   = 13;
    localparam int EXTENT_W = 12;
    localparam int SIZE_W   = 13;
    localparam int ORIGIN_W = 12;
    localparam int CTR_W    = 15;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RESET  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RESET = SIZE_W'(480);

    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_SAMPLE  = 1'b1;

    localparam logic RESULT_ORIGIN = 1'b0;
    localparam logic RESULT_MEDIAN = 1'b1;

    typedef struct packed {
        logic insert;
        logic [DEPTH_W-1:0] sample;
        logic [CNT_W-1:0] count;
    } sort_cmd_t;

    typedef struct packed {
        logic insert;
        logic occupied;
        logic tail;
    } cell_ctl_t;

endpackage

// ===== src/wmdg_cell.sv =====
// one insertion cell of the sorted sample chain
module wmdg_cell
    import wmdg_pkg::*;
(
    input  logic               clk,
    input  cell_ctl_t          ctl,
    input  logic [DEPTH_W-1:0] sample,
    input  logic [DEPTH_W-1:0] prev_val,
    input  logic               prev_gt,
    output logic [DEPTH_W-1:0] val,
    output logic               gt
);

    logic [DEPTH_W-1:0] val_reg;
    logic [DEPTH_W-1:0] val_next;

    assign gt  = ctl.occupied && (val_reg > sample);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctl.insert && (gt || ctl.tail))
        begin
            val_next = prev_gt ? prev_val : sample;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ===== src/wmdg_sort_chain.sv =====
// row of insertion cells holding the window samples in ascending order
module wmdg_sort_chain
    import wmdg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  sort_cmd_t          cmd,
    output logic [DEPTH_W-1:0] median
);

    logic [DEPTH_W-1:0] cell_val [WIN_COUNT];
    logic               cell_gt  [WIN_COUNT];

    genvar i;
    generate
        for (i = 0; i < WIN_COUNT; i++)
        begin : g_cell
            cell_ctl_t          ctl;
            logic [DEPTH_W-1:0] prev_val;
            logic               prev_gt;

            assign ctl.insert   = cmd.insert;
            assign ctl.occupied = cmd.count > CNT_W'(i);
            assign ctl.tail     = cmd.count == CNT_W'(i);

            if (i == 0)
            begin : g_head
                assign prev_val = '0;
                assign prev_gt  = 1'b0;
            end
            else
            begin : g_body
                assign prev_val = cell_val[i-1];
                assign prev_gt  = cell_gt[i-1];
            end

            wmdg_cell u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .sample   (cmd.sample),
                .prev_val (prev_val),
                .prev_gt  (prev_gt),
                .val      (cell_val[i]),
                .gt       (cell_gt[i])
            );
        end
    endgenerate

    assign median = cell_val[MED_RANK];

    generate
        for (i = 0; i < WIN_COUNT - 1; i++)
        begin : g_order_chk
            a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
                (cmd.count > CNT_W'(i + 1)) |-> (cell_val[i] <= cell_val[i+1]))
                else $error("sample chain out of order");
        end
    endgenerate

endmodule

// ===== src/wmdg_origin.sv =====
// clamps a window centre into the image and gives the window origin
module wmdg_origin
    import wmdg_pkg::*;
(
    input  logic signed [CTR_W-1:0] centre,
    input  logic [SIZE_W-1:0]       size,
    output logic [ORIGIN_W-1:0]     origin
);

    localparam logic signed [CTR_W-1:0] RADIUS_S = CTR_W'(WINDOW_RADIUS);
    localparam logic signed [CTR_W-1:0] ORIGIN_TOP = CTR_W'((1 << ORIGIN_W) - 1);

    logic signed [CTR_W-1:0] upper;
    logic signed [CTR_W-1:0] lim_hi;
    logic signed [CTR_W-1:0] lim_lo;
    logic signed [CTR_W-1:0] shifted;

    always_comb
    begin
        upper   = $signed(CTR_W'(size)) - RADIUS_S - CTR_W'(1);
        lim_hi  = (centre > upper) ? upper : centre;
        lim_lo  = (lim_hi < RADIUS_S) ? RADIUS_S : lim_hi;
        shifted = lim_lo - RADIUS_S;
        origin  = (shifted > ORIGIN_TOP) ? ORIGIN_TOP[ORIGIN_W-1:0]
                                         : shifted[ORIGIN_W-1:0];
    end

endmodule

// ===== src/bbox_window_median_depth_gate.sv =====
// top level: window origin from a box request, median depth gate over the window samples
// path: an accepted item that gives a result passes the middle stage, then the output register
// throughput: one item per cycle while req_stall is low; the chain places each sample directly
// an item that gives no result (a sample not marked last) sets no valid in the middle stage
// reset: image size registers go to 640 by 480, held depth and tolerance to zero,
// sample count to zero; the sample cells are not cleared and no clearing pass runs
module bbox_window_median_depth_gate
    import wmdg_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [APB_ADDR_W-1:0]       paddr,
    input  logic [APB_DATA_W-1:0]       pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready,

    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic                        kind,
    input  logic signed [EDGE_W-1:0]    box_left,
    input  logic signed [EDGE_W-1:0]    box_top,
    input  logic [EXTENT_W-1:0]         box_width,
    input  logic [EXTENT_W-1:0]         box_height,
    input  logic [DEPTH_W-1:0]          expected_depth,
    input  logic [DEPTH_W-1:0]          depth_tolerance,
    input  logic [DEPTH_W-1:0]          depth_sample,
    input  logic                        last_sample,

    output logic                        res_valid,
    input  logic                        res_stall,
    output logic                        result_kind,
    output logic [ORIGIN_W-1:0]         window_x,
    output logic [ORIGIN_W-1:0]         window_y,
    output logic [DEPTH_W-1:0]          median_depth,
    output logic                        depth_valid
);

    logic [SIZE_W-1:0]  image_width_reg;
    logic [SIZE_W-1:0]  image_height_reg;
    logic [DEPTH_W-1:0] held_expected_reg;
    logic [DEPTH_W-1:0] held_tolerance_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    logic                    mid_valid_reg;
    logic                    mid_kind_reg;
    logic                    mid_complete_reg;
    logic signed [CTR_W-1:0] mid_cx_reg;
    logic signed [CTR_W-1:0] mid_cy_reg;

    logic                res_valid_reg;
    logic                res_kind_reg;
    logic [ORIGIN_W-1:0] res_x_reg;
    logic [ORIGIN_W-1:0] res_y_reg;
    logic [DEPTH_W-1:0]  res_median_reg;
    logic                res_ok_reg;

    logic                    cfg_write;
    logic                    req_accept;
    logic                    produces;
    logic                    out_load_ok;
    logic signed [CTR_W-1:0] cx_next;
    logic signed [CTR_W-1:0] cy_next;
    sort_cmd_t               cmd;
    logic [DEPTH_W-1:0]      median;
    logic [ORIGIN_W-1:0]     org_x;
    logic [ORIGIN_W-1:0]     org_y;
    logic [DEPTH_W:0]        diff;
    logic                    res_kind_next;
    logic [ORIGIN_W-1:0]     res_x_next;
    logic [ORIGIN_W-1:0]     res_y_next;
    logic [DEPTH_W-1:0]      res_median_next;
    logic                    res_ok_next;

    // apb register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_IDX_WIDTH:  prdata = APB_DATA_W'(image_width_reg);
            REG_IDX_HEIGHT: prdata = APB_DATA_W'(image_height_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RESET;
            image_height_reg <= IMAGE_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_IDX_WIDTH:  image_width_reg  <= pwdata[SIZE_W-1:0];
                REG_IDX_HEIGHT: image_height_reg <= pwdata[SIZE_W-1:0];
                default:        image_width_reg  <= image_width_reg;
            endcase
        end
    end

    // item handshake
    assign out_load_ok = !res_valid_reg || !res_stall;
    assign req_stall   = mid_valid_reg && !out_load_ok;
    assign req_accept  = req_valid && !req_stall;
    assign produces    = (kind == KIND_REQUEST) || last_sample;

    assign cx_next = CTR_W'(box_left) + $signed(CTR_W'(box_width >> 1));
    assign cy_next = CTR_W'(box_top) + $signed(CTR_W'(box_height >> 1));

    assign cmd.insert = req_accept && (kind == KIND_SAMPLE)
                        && (cnt_reg < CNT_W'(WIN_COUNT));
    assign cmd.sample = depth_sample;
    assign cmd.count  = cnt_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (req_accept)
        begin
            if (kind == KIND_REQUEST || last_sample)
            begin
                cnt_next = '0;
            end
            else if (cnt_reg < CNT_W'(WIN_COUNT))
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg            <= '0;
            held_expected_reg  <= '0;
            held_tolerance_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (req_accept && kind == KIND_REQUEST)
            begin
                held_expected_reg  <= expected_depth;
                held_tolerance_reg <= depth_tolerance;
            end
        end
    end

    wmdg_sort_chain u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .median (median)
    );

    // middle stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
        end
        else if (!mid_valid_reg || out_load_ok)
        begin
            mid_valid_reg <= req_accept && produces;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            mid_kind_reg     <= kind;
            mid_complete_reg <= cnt_reg >= CNT_W'(WIN_COUNT - 1);
            mid_cx_reg       <= cx_next;
            mid_cy_reg       <= cy_next;
        end
    end

    wmdg_origin u_origin_x (
        .centre (mid_cx_reg),
        .size   (image_width_reg),
        .origin (org_x)
    );

    wmdg_origin u_origin_y (
        .centre (mid_cy_reg),
        .size   (image_height_reg),
        .origin (org_y)
    );

    always_comb
    begin
        diff = (held_expected_reg > median)
               ? {1'b0, held_expected_reg} - {1'b0, median}
               : {1'b0, median} - {1'b0, held_expected_reg};
        if (mid_kind_reg == KIND_REQUEST)
        begin
            res_kind_next   = RESULT_ORIGIN;
            res_x_next      = org_x;
            res_y_next      = org_y;
            res_median_next = '0;
            res_ok_next     = 1'b0;
        end
        else
        begin
            res_kind_next   = RESULT_MEDIAN;
            res_x_next      = '0;
            res_y_next      = '0;
            res_median_next = mid_complete_reg ? median : '0;
            res_ok_next     = mid_complete_reg
                              && (diff <= {1'b0, held_tolerance_reg});
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_load_ok)
        begin
            res_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load_ok && mid_valid_reg)
        begin
            res_kind_reg   <= res_kind_next;
            res_x_reg      <= res_x_next;
            res_y_reg      <= res_y_next;
            res_median_reg <= res_median_next;
            res_ok_reg     <= res_ok_next;
        end
    end

    assign res_valid    = res_valid_reg;
    assign result_kind  = res_kind_reg;
    assign window_x     = res_x_reg;
    assign window_y     = res_y_reg;
    assign median_depth = res_median_reg;
    assign depth_valid  = res_ok_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(WIN_COUNT))
        else $error("sample count beyond window size");

    a_request_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && kind == KIND_REQUEST) |=> (cnt_reg == '0))
        else $error("request did not empty the sample store");

    a_origin_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_kind_reg == RESULT_ORIGIN)
            |-> (res_median_reg == '0 && !res_ok_reg))
        else $error("origin item carries depth data");

    a_no_stall_free_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (!mid_valid_reg) |-> !req_stall)
        else $error("input stalled with empty middle stage");

endmodule
